FILE: rtl/core/ordered_list_insert_remove_find_core_macros.svh
// assertion shorthands, sampled on clk with reset arst_n held off
`ifndef ORDERED_LIST_INSERT_REMOVE_FIND_CORE_MACROS_SVH
`define ORDERED_LIST_INSERT_REMOVE_FIND_CORE_MACROS_SVH

// same-cycle implication
`define OLI_ASSERT_IMP(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define OLI_ASSERT_NXT(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/core/olist_pkg.sv
`default_nettype none

package olist_pkg;

	localparam int KEY_W  = 64;
	localparam int PAY_W  = 32;
	localparam int POS_W  = 7;
	localparam int FPOS_W = 6;
	localparam int CNT_W  = 7;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_FIND   = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_DEL,
		S_FIND,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [POS_W-1:0] position;
		logic [KEY_W-1:0] entry_key;
		logic [PAY_W-1:0] entry_payload;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [FPOS_W-1:0] found_position;
		logic [PAY_W-1:0]  found_payload;
		logic [CNT_W-1:0]  list_count;
	} rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/ordered_list_insert_remove_find_core.sv
// Ordered list of up to CAPACITY records (64-bit key, 32-bit payload) held in
// one single-port-write, one-port-read synchronous RAM.
// Request channel req_valid / req_stall / req: insert at a position, find by
// key, or remove at a position. Response channel rsp_valid / rsp_stall / rsp:
// exactly one beat per request with status, found position and payload, and
// the entry count after the request.
// One request is worked at a time; req_stall is high from the accepting edge
// until the response is loaded into the output register. The RAM moves one
// entry per cycle: insert shifts entries p..n-1 up one slot, remove shifts
// entries p+1..n-1 down one slot, and find reads entries in order and stops
// at the first hit; rejected or unused requests go straight to the response.
// The response beat appears in the same cycle that the next request can be
// taken.
// A response waiting under rsp_stall holds; a finished request waits for the
// output register to drain before the next request is taken.
// Reset empties the list at once (count cleared); RAM contents are not
// cleared since only entries below the count are ever read.
`default_nettype none
`include "ordered_list_insert_remove_find_core_macros.svh"

module ordered_list_insert_remove_find_core #(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  olist_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output olist_pkg::rsp_t   rsp
);

	import olist_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam int DW = KEY_W + PAY_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	state_t            state_q, state_d;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     pos_q;
	logic [CW-1:0]     idx_q;
	logic [KEY_W-1:0]  key_q;
	logic [PAY_W-1:0]  pay_q;
	status_t           status_q;
	logic [AW-1:0]     fpos_q;
	logic [PAY_W-1:0]  fpay_q;
	logic              pend_s1;
	logic [AW-1:0]     addr_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr, wr_addr, tgt_addr;
	logic [DW-1:0]     wr_data, rd_data_s1;

	logic              acc, rsp_free, match_s1, idx_gt_pos, idx_lt_cnt;
	logic [PW-1:0]     pos_ext, cnt_ext;

	assign acc        = req_valid && !req_stall;
	assign req_stall  = (state_q != S_IDLE);
	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign pos_ext    = PW'(req.position);
	assign cnt_ext    = PW'(cnt_q);
	assign idx_gt_pos = (idx_q > pos_q);
	assign idx_lt_cnt = (idx_q < cnt_q);
	assign match_s1   = pend_s1 && (rd_data_s1[DW-1:PAY_W] == key_q);

	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	olist_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.DW    (DW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data_s1)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.req_type)
						REQ_INSERT: begin
							if (pos_ext > cnt_ext || cnt_q == CAP_C) begin
								state_d = S_DONE;
							end else begin
								state_d = S_INS;
							end
						end
						REQ_FIND: state_d = S_FIND;
						REQ_REMOVE: begin
							if (pos_ext >= cnt_ext) begin
								state_d = S_DONE;
							end else begin
								state_d = S_DEL;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_INS: begin
				if (!pend_s1 && !idx_gt_pos) begin
					state_d = S_DONE;
				end
			end
			S_DEL: begin
				if (!pend_s1 && !idx_lt_cnt) begin
					state_d = S_DONE;
				end
			end
			S_FIND: begin
				if (match_s1 || (!pend_s1 && !idx_lt_cnt)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ram access: shifts write each entry read one slot over the next cycle
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		tgt_addr = '0;
		wr_en    = 1'b0;
		wr_addr  = addr_s1;
		wr_data  = rd_data_s1;
		case (state_q)
			S_INS: begin
				rd_en    = idx_gt_pos;
				rd_addr  = AW'(idx_q - CW'(1));
				tgt_addr = AW'(idx_q);
				if (pend_s1) begin
					wr_en = 1'b1;
				end else if (!idx_gt_pos) begin
					wr_en   = 1'b1;
					wr_addr = AW'(pos_q);
					wr_data = {key_q, pay_q};
				end
			end
			S_DEL: begin
				rd_en    = idx_lt_cnt;
				rd_addr  = AW'(idx_q);
				tgt_addr = AW'(idx_q - CW'(1));
				wr_en    = pend_s1;
			end
			S_FIND: begin
				rd_en    = idx_lt_cnt && !match_s1;
				rd_addr  = AW'(idx_q);
				tgt_addr = AW'(idx_q);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= rd_en;
			if (state_q == S_INS && state_d == S_DONE) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == S_DEL && state_d == S_DONE) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1 <= tgt_addr;
		end
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					pos_q    <= CW'(req.position);
					key_q    <= req.entry_key;
					pay_q    <= req.entry_payload;
					fpos_q   <= '0;
					fpay_q   <= '0;
					case (req.req_type)
						REQ_INSERT: begin
							idx_q <= cnt_q;
							if (pos_ext > cnt_ext) begin
								status_q <= ST_RANGE;
							end else if (cnt_q == CAP_C) begin
								status_q <= ST_FULL;
							end else begin
								status_q <= ST_OK;
							end
						end
						REQ_REMOVE: begin
							idx_q <= CW'(req.position) + CW'(1);
							if (pos_ext >= cnt_ext) begin
								status_q <= ST_RANGE;
							end else begin
								status_q <= ST_OK;
							end
						end
						default: begin
							idx_q    <= '0;
							status_q <= ST_OK;
						end
					endcase
				end
			end
			S_INS: begin
				if (rd_en) begin
					idx_q <= idx_q - CW'(1);
				end
			end
			S_DEL: begin
				if (rd_en) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			S_FIND: begin
				if (rd_en) begin
					idx_q <= idx_q + CW'(1);
				end
				if (match_s1) begin
					fpos_q <= addr_s1;
					fpay_q <= rd_data_s1[PAY_W-1:0];
				end else if (!pend_s1 && !idx_lt_cnt) begin
					status_q <= ST_MISSING;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					rsp_q.status         <= status_q;
					rsp_q.found_position <= FPOS_W'(fpos_q);
					rsp_q.found_payload  <= fpay_q;
					rsp_q.list_count     <= CNT_W'(cnt_q);
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	`OLI_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_q <= CAP_C, "entry count beyond capacity")
	`OLI_ASSERT_IMP(a_rw_clash, rd_en && wr_en, rd_addr != wr_addr, "read and write on one entry")
	`OLI_ASSERT_NXT(a_acc_busy, acc, state_q != S_IDLE, "accepted beat left the sequencer idle")
	`OLI_ASSERT_NXT(a_cnt_hold, state_q == S_IDLE || state_q == S_FIND || state_q == S_DONE, $stable(cnt_q), "count moved outside a shift")
	`OLI_ASSERT_IMP(a_rsp_src, $rose(rsp_valid_q), $past(state_q) == S_DONE, "response without a finished request")

endmodule

`default_nettype wire

FILE: rtl/core/olist_ram.sv
`default_nettype none

module olist_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 96
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: sim/ordered_list_insert_remove_find_core_tb.sv
`timescale 1ns / 100ps

module ordered_list_insert_remove_find_core_tb;
	import olist_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	// mirror of the list, updated as each request beat is taken
	class olist_scoreboard;
		logic [KEY_W-1:0] keys [LIST_DEPTH];
		logic [PAY_W-1:0] pays [LIST_DEPTH];
		int count;
		rsp_t outcome_q [$];
		int unsigned errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		function rsp_t apply_request(req_t r);
			rsp_t o;
			int i;
			bit hit;
			o.status = ST_OK;
			o.found_position = '0;
			o.found_payload = '0;
			hit = 1'b0;
			case (r.req_type)
				REQ_INSERT: begin
					if (int'(r.position) > count) begin
						o.status = ST_RANGE;
					end else if (count >= LIST_DEPTH) begin
						o.status = ST_FULL;
					end else begin
						for (i = count; i > int'(r.position); i--) begin
							keys[i] = keys[i-1];
							pays[i] = pays[i-1];
						end
						keys[r.position] = r.entry_key;
						pays[r.position] = r.entry_payload;
						count++;
					end
				end
				REQ_FIND: begin
					for (i = 0; i < count; i++) begin
						if (!hit && keys[i] == r.entry_key) begin
							hit = 1'b1;
							o.found_position = i[FPOS_W-1:0];
							o.found_payload = pays[i];
						end
					end
					if (!hit)
						o.status = ST_MISSING;
				end
				REQ_REMOVE: begin
					if (int'(r.position) >= count) begin
						o.status = ST_RANGE;
					end else begin
						for (i = int'(r.position); i + 1 < count; i++) begin
							keys[i] = keys[i+1];
							pays[i] = pays[i+1];
						end
						count--;
					end
				end
				default: ;
			endcase
			o.list_count = CNT_W'(count);
			return o;
		endfunction

		function void note_request(req_t r);
			outcome_q.push_back(apply_request(r));
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (outcome_q.size() == 0) begin
				$error("response beat with nothing outstanding: status %0d count %0d",
					got.status, got.list_count);
				errors++;
				return;
			end
			want = outcome_q.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.found_position !== want.found_position) begin
				$error("found_position: expected %0d, got %0d",
					want.found_position, got.found_position);
				errors++;
			end
			if (got.found_payload !== want.found_payload) begin
				$error("found_payload: expected %h, got %h",
					want.found_payload, got.found_payload);
				errors++;
			end
			if (got.list_count !== want.list_count) begin
				$error("list_count: expected %0d, got %0d", want.list_count, got.list_count);
				errors++;
			end
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	olist_scoreboard list_sb;

	int burst_left = 0;
	int rsp_beats = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int stall_phase_left = 0;
	int idle_cycles = 0;

	ordered_list_insert_remove_find_core #(
		.CAPACITY(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic req_t mk_req(logic [1:0] kind, int pos, logic [KEY_W-1:0] key,
			logic [PAY_W-1:0] pay);
		req_t r;
		r.req_type = kind;
		r.position = POS_W'(pos);
		r.entry_key = key;
		r.entry_payload = pay;
		return r;
	endfunction

	// small values and near-all-ones give plenty of duplicate keys
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(3))
			0: return KEY_W'($urandom_range(7));
			1: return ~KEY_W'($urandom_range(3));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic req_t make_request(int ins_w, int rem_w);
		req_t r;
		int roll;
		int n;
		int sel;
		n = list_sb.count;
		roll = $urandom_range(99);
		sel = $urandom_range(19);
		r.position = POS_W'($urandom_range(127));
		r.entry_key = pick_key();
		r.entry_payload = $urandom;
		if (roll < ins_w) begin
			r.req_type = REQ_INSERT;
			if (sel < 17)
				r.position = POS_W'($urandom_range(n, 0));
			else if (sel == 17)
				r.position = POS_W'(n + 1);
		end else if (roll < ins_w + rem_w) begin
			r.req_type = REQ_REMOVE;
			if (sel < 17 && n > 0)
				r.position = POS_W'($urandom_range(n - 1, 0));
			else if (sel == 17)
				r.position = POS_W'(n);
		end else if (roll < 97) begin
			r.req_type = REQ_FIND;
			if (sel < 12 && n > 0)
				r.entry_key = list_sb.keys[$urandom_range(n - 1, 0)];
		end else begin
			r.req_type = REQ_SPARE;
		end
		return r;
	endfunction

	// sender runs in bursts; a zero gap keeps valid high across bursts
	task automatic send_request(input req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(16, 1);
			gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		list_sb.note_request(r);
	endtask

	// response side: checks beats and drives its own stall pattern
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			list_sb.check_response(rsp);
			rsp_beats++;
			if (rsp_beats == 40)
				hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			if (stall_phase_left == 0) begin
				stall_mode = $urandom_range(3);
				stall_phase_left = $urandom_range(80, 20);
			end
			stall_phase_left--;
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(3) == 0);
				2: rsp_stall <= ($urandom_range(3) != 0);
				default: rsp_stall <= ~rsp_stall;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL ordered_list_insert_remove_find_core");
			$finish;
		end
	end

	initial begin
		int guard;
		list_sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, extremes, duplicates, rejects and the spare code
		send_request(mk_req(REQ_FIND, 0, '0, '0));
		send_request(mk_req(REQ_REMOVE, 0, '0, '0));
		send_request(mk_req(REQ_INSERT, 1, 64'h1, 32'h1));
		send_request(mk_req(REQ_INSERT, 0, '1, '1));
		send_request(mk_req(REQ_INSERT, 0, '0, '0));
		send_request(mk_req(REQ_INSERT, 2, 64'h5, 32'h1234_5678));
		send_request(mk_req(REQ_INSERT, 1, '1, 32'ha5a5_a5a5));
		send_request(mk_req(REQ_FIND, 127, '1, '1));
		send_request(mk_req(REQ_FIND, 0, '0, '0));
		send_request(mk_req(REQ_FIND, 0, 64'h5, '0));
		send_request(mk_req(REQ_FIND, 0, 64'h8000_0000_0000_0000, '0));
		send_request(mk_req(REQ_SPARE, 127, '1, '1));
		send_request(mk_req(REQ_INSERT, 127, '1, '1));
		send_request(mk_req(REQ_INSERT, 5, 64'h6, 32'h6));
		send_request(mk_req(REQ_REMOVE, 4, '0, '0));
		send_request(mk_req(REQ_REMOVE, 127, '0, '0));
		send_request(mk_req(REQ_REMOVE, 1, '0, '0));
		send_request(mk_req(REQ_FIND, 0, '1, '0));
		send_request(mk_req(REQ_REMOVE, 2, '0, '0));
		send_request(mk_req(REQ_REMOVE, 0, '0, '0));
		send_request(mk_req(REQ_FIND, 0, '0, '0));
		send_request(mk_req(REQ_INSERT, 1, 64'h7, 32'h7));
		send_request(mk_req(REQ_REMOVE, 0, '0, '0));

		for (int k = 0; k < 100; k++)
			send_request(make_request(45, 30));
		// fill to capacity, then hammer the full list
		guard = 0;
		while (list_sb.count < LIST_DEPTH && guard < 400) begin
			send_request(make_request(85, 5));
			guard++;
		end
		for (int k = 0; k < 20; k++)
			send_request(make_request(60, 5));
		for (int k = 0; k < 60; k++)
			send_request(make_request(45, 40));
		guard = 0;
		while (list_sb.count > 0 && guard < 400) begin
			send_request(make_request(5, 85));
			guard++;
		end
		for (int k = 0; k < 100; k++)
			send_request(make_request(40, 35));
		req_valid <= 1'b0;

		while (list_sb.pending() != 0)
			@(posedge clk);
		repeat (LIST_DEPTH + 8) @(posedge clk);
		if (list_sb.errors == 0)
			$display("PASS ordered_list_insert_remove_find_core");
		else
			$display("FAIL ordered_list_insert_remove_find_core");
		$finish;
	end

endmodule
